>>> rtl/nglc_pkg.sv
// shared types, constants and helper functions of the gga line checker
package nglc_pkg;

  localparam int LINE_MAX_DEF    = 256;
  localparam int FIELD_LIMIT_DEF = 32;
  localparam int MIN_FIELDS      = 15;
  localparam int FIX_FIELD       = 6;
  localparam int SATS_FIELD      = 7;
  localparam int HEAD_LEN        = 6;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_GGA    = 2'd1;
  localparam logic [1:0] ST_BAD_SUM    = 2'd2;
  localparam logic [1:0] ST_FEW_FIELDS = 2'd3;

  // first member sits in the highest bits, so status lands at bit 0
  typedef struct packed {
    logic [7:0] sats_used;
    logic [7:0] fix_quality;
    logic [5:0] field_count;
    logic [7:0] recv_checksum;
    logic [7:0] calc_checksum;
    logic [1:0] status;
  } nglc_result_t;

  localparam int RESULT_W = $bits(nglc_result_t);

  // "$GPGGA"
  function automatic logic [7:0] head_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_DOLLAR;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h47;
      3'd5:    ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_of(input logic [7:0] ch);
    logic [4:0] h;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      h = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      h = {1'b1, 4'(ch - 8'h37)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      h = {1'b1, 4'(ch - 8'h57)};
    end else begin
      h = 5'd0;
    end
    return h;
  endfunction

  // acc * 10 + digit, saturating at 255
  function automatic logic [7:0] dec_push(input logic [7:0] acc, input logic [3:0] digit);
    logic [11:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, digit};
    return (v > 12'd255) ? 8'hff : v[7:0];
  endfunction

endpackage

>>> rtl/nglc_line_state.sv
// per-line state registers and the per-character update of the gga line checker
module nglc_line_state
  import nglc_pkg::*;
#(
  parameter int LINE_MAX    = LINE_MAX_DEF,
  parameter int FIELD_LIMIT = FIELD_LIMIT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  output logic         line_end,
  output nglc_result_t result
);

  localparam int CW = $clog2(LINE_MAX);
  localparam int FW = $clog2(FIELD_LIMIT);

  logic [CW-1:0] char_pos;
  logic          header_ok;
  logic [7:0]    xor_acc;
  logic          star_seen;
  logic [1:0]    hex_digits;
  logic [7:0]    hex_value;
  logic          hex_bad;
  logic [FW-1:0] field_index;
  logic          digit_stop;
  logic [7:0]    fix_acc;
  logic [7:0]    sats_acc;

  logic          header_ok_next;
  logic [7:0]    xor_acc_next;
  logic          star_seen_next;
  logic [1:0]    hex_digits_next;
  logic [7:0]    hex_value_next;
  logic          hex_bad_next;
  logic [FW-1:0] field_index_next;
  logic          digit_stop_next;
  logic [7:0]    fix_acc_next;
  logic [7:0]    sats_acc_next;

  logic [4:0]    hex;
  logic          is_digit;
  logic          in_head;
  logic          hdr;
  logic          present;
  logic [5:0]    fields;

  assign hex      = hex_of(rx_byte);
  assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign in_head  = char_pos < CW'(HEAD_LEN);

  always_comb begin
    header_ok_next   = header_ok;
    xor_acc_next     = xor_acc;
    star_seen_next   = star_seen;
    hex_digits_next  = hex_digits;
    hex_value_next   = hex_value;
    hex_bad_next     = hex_bad;
    field_index_next = field_index;
    digit_stop_next  = digit_stop;
    fix_acc_next     = fix_acc;
    sats_acc_next    = sats_acc;

    if (in_head && rx_byte != head_char(char_pos[2:0])) begin
      header_ok_next = 1'b0;
    end

    if (star_seen) begin
      if (!hex_bad && hex_digits != 2'd2) begin
        if (hex[4]) begin
          hex_value_next  = {hex_value[3:0], hex[3:0]};
          hex_digits_next = hex_digits + 2'd1;
        end else begin
          hex_bad_next = 1'b1;
        end
      end
    end else if (rx_byte == CH_STAR) begin
      star_seen_next = 1'b1;
    end else begin
      if (!(char_pos == '0 && rx_byte == CH_DOLLAR)) begin
        xor_acc_next = xor_acc ^ rx_byte;
      end
      if (rx_byte == CH_COMMA) begin
        if (field_index != FW'(FIELD_LIMIT - 1)) begin
          field_index_next = field_index + FW'(1);
        end
        digit_stop_next = 1'b0;
      end else if (!digit_stop) begin
        if (is_digit) begin
          if (field_index == FW'(FIX_FIELD)) begin
            fix_acc_next = dec_push(fix_acc, rx_byte[3:0]);
          end else if (field_index == FW'(SATS_FIELD)) begin
            sats_acc_next = dec_push(sats_acc, rx_byte[3:0]);
          end
        end else begin
          digit_stop_next = 1'b1;
        end
      end
    end
  end

  assign line_end = (rx_byte == CH_NEWLINE) || (char_pos == CW'(LINE_MAX - 1));

  // the header needs at least six characters in the line
  assign hdr     = header_ok_next && (char_pos >= CW'(HEAD_LEN - 1));
  assign present = star_seen_next &&
                   (hex_digits_next == 2'd2 || (hex_digits_next == 2'd1 && hex_bad_next));
  assign fields  = 6'(field_index_next) + 6'd1;

  always_comb begin
    if (!hdr) begin
      result.status = ST_NOT_GGA;
    end else if (!present || hex_value_next != xor_acc_next) begin
      result.status = ST_BAD_SUM;
    end else if (fields < 6'(MIN_FIELDS)) begin
      result.status = ST_FEW_FIELDS;
    end else begin
      result.status = ST_OK;
    end
    result.calc_checksum = xor_acc_next;
    result.recv_checksum = hex_value_next;
    result.field_count   = fields;
    result.fix_quality   = fix_acc_next;
    result.sats_used     = sats_acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && line_end)) begin
      char_pos    <= '0;
      header_ok   <= 1'b1;
      xor_acc     <= 8'd0;
      star_seen   <= 1'b0;
      hex_digits  <= 2'd0;
      hex_value   <= 8'd0;
      hex_bad     <= 1'b0;
      field_index <= '0;
      digit_stop  <= 1'b0;
      fix_acc     <= 8'd0;
      sats_acc    <= 8'd0;
    end else if (step) begin
      char_pos    <= char_pos + CW'(1);
      header_ok   <= header_ok_next;
      xor_acc     <= xor_acc_next;
      star_seen   <= star_seen_next;
      hex_digits  <= hex_digits_next;
      hex_value   <= hex_value_next;
      hex_bad     <= hex_bad_next;
      field_index <= field_index_next;
      digit_stop  <= digit_stop_next;
      fix_acc     <= fix_acc_next;
      sats_acc    <= sats_acc_next;
    end
  end

endmodule

>>> rtl/nmea_gga_line_checker.sv
// top level of the gga line checker: input register, line state and result register
//
// Takes one received character per item on the s_ side and emits one result item
// on the m_ side for each line, at the newline or at the character that brings the
// line to LINE_MAX characters. A character passes an input register, updates the
// per-line state and, at a line end, loads the result register, so the block takes
// one character every clock cycle when the input side is not held; the result register
// loads as the character that ends its line leaves the input register. Only a line end
// that meets a result still waiting on m_tready holds the input side. Status: 0 accepted,
// 1 not a $GPGGA line, 2 checksum missing or wrong, 3 fewer than 15 fields.
module nmea_gga_line_checker
  import nglc_pkg::*;
#(
  parameter int LINE_MAX    = LINE_MAX_DEF,
  parameter int FIELD_LIMIT = FIELD_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,  // rx_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  // status[1:0], calc_checksum[9:2], recv_checksum[17:10], field_count[23:18],
  // fix_quality[31:24], sats_used[39:32]
  output logic [RESULT_W-1:0] m_tdata
);

  logic         b_valid;
  logic [7:0]   b_data;
  logic         b_adv;
  logic         line_end;
  nglc_result_t result;
  logic         o_valid;
  nglc_result_t o_data;

  assign b_adv    = b_valid && (!line_end || !o_valid || m_tready);
  assign s_tready = !b_valid || b_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (s_tready) begin
      b_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      b_data <= s_tdata;
    end
  end

  nglc_line_state #(
    .LINE_MAX    (LINE_MAX),
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_line (
    .clk      (clk),
    .rst      (rst),
    .step     (b_adv),
    .rx_byte  (b_data),
    .line_end (line_end),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (b_adv && line_end) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && line_end) begin
      o_data <= result;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;

endmodule

>>> rtl/nglc_checker.sv
// port checks of the gga line checker and their binding to the top level
module nglc_checker
  import nglc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [7:0]          s_tdata,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [RESULT_W-1:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a line always has at least one field
  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:18] != 6'd0)
    else $error("zero field count");

  // accepted and few-fields lines passed the checksum test
  a_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_FEW_FIELDS)
    |-> m_tdata[9:2] == m_tdata[17:10])
    else $error("checksum mismatch on a line past the checksum test");

  a_few: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_FEW_FIELDS |-> m_tdata[23:18] < 6'(MIN_FIELDS))
    else $error("few-fields status with enough fields");

  // a newline item brings a result out after passing the input and result registers
  a_newline: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata == CH_NEWLINE |-> ##2 m_tvalid)
    else $error("no result after newline");

endmodule

bind nmea_gga_line_checker nglc_checker u_nglc_checker (.*);

>>> tb/sv/nmea_gga_line_checker_tb.sv
// testbench for the gga line checker: directed and random lines checked against a line predictor
`timescale 1ns / 1ps

module nmea_gga_line_checker_tb;
  import nglc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [47:0] GGA_HEAD = "$GPGGA";
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_DOT = ".";

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [RESULT_W-1:0] m_tdata;

  nmea_gga_line_checker #(
    .LINE_MAX(LINE_MAX_DEF),
    .FIELD_LIMIT(FIELD_LIMIT_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // per-line state of the predictor
  logic [8:0] ln_pos;
  logic ln_head_ok;
  logic [7:0] ln_xor;
  logic ln_star;
  logic [1:0] ln_hex_n;
  logic [7:0] ln_hex_val;
  logic ln_hex_broken;
  logic [5:0] ln_field;
  logic ln_num_done;
  logic [7:0] ln_fix;
  logic [7:0] ln_sats;

  nglc_result_t expected_line_results[$];
  nglc_result_t got_line;
  nglc_result_t want_line;
  logic [7:0] line_buf[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int chars_sent = 0;
  int lines_predicted = 0;
  int lines_checked = 0;
  int cycle_count = 0;
  int status_seen[4];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lines still pending", cycle_count,
               expected_line_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("line %0d: %s is %0d, expected %0d", lines_checked, what, got, want);
  endtask

  function automatic logic [7:0] sat_decimal(input logic [7:0] acc, input logic [7:0] digit);
    int v;
    v = int'(acc) * 10 + int'(digit);
    return (v > 255) ? 8'hff : 8'(v);
  endfunction

  task clear_line_state();
    ln_pos = '0;
    ln_head_ok = 1'b1;
    ln_xor = '0;
    ln_star = 1'b0;
    ln_hex_n = '0;
    ln_hex_val = '0;
    ln_hex_broken = 1'b0;
    ln_field = '0;
    ln_num_done = 1'b0;
    ln_fix = '0;
    ln_sats = '0;
  endtask

  task gga_line_step(input logic [7:0] ch);
    int p;
    logic is_hex;
    logic [3:0] nib;
    logic head_good;
    logic sum_present;
    nglc_result_t r;
    p = int'(ln_pos);
    if (p < HEAD_LEN && ch != GGA_HEAD[8*(5-p) +: 8]) ln_head_ok = 1'b0;
    if (ln_star) begin
      if (!ln_hex_broken && ln_hex_n < 2) begin
        is_hex = 1'b1;
        nib = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE) nib = 4'(ch - CH_ZERO);
        else if (ch >= "A" && ch <= "F") nib = 4'(ch - "A" + 8'd10);
        else if (ch >= "a" && ch <= "f") nib = 4'(ch - "a" + 8'd10);
        else is_hex = 1'b0;
        if (is_hex) begin
          ln_hex_val = {ln_hex_val[3:0], nib};
          ln_hex_n++;
        end else begin
          ln_hex_broken = 1'b1;
        end
      end
    end else if (ch == CH_STAR) begin
      ln_star = 1'b1;
    end else begin
      if (!(p == 0 && ch == CH_DOLLAR)) ln_xor ^= ch;
      if (ch == CH_COMMA) begin
        if (int'(ln_field) + 1 < FIELD_LIMIT_DEF) ln_field++;
        ln_num_done = 1'b0;
      end else if (!ln_num_done) begin
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          if (ln_field == FIX_FIELD) ln_fix = sat_decimal(ln_fix, ch - CH_ZERO);
          else if (ln_field == SATS_FIELD) ln_sats = sat_decimal(ln_sats, ch - CH_ZERO);
        end else begin
          ln_num_done = 1'b1;
        end
      end
    end
    ln_pos++;
    if (ch == CH_NEWLINE || int'(ln_pos) >= LINE_MAX_DEF) begin
      head_good = ln_head_ok && int'(ln_pos) >= HEAD_LEN;
      sum_present = ln_star && (ln_hex_n == 2 || (ln_hex_n == 1 && ln_hex_broken));
      if (!head_good) r.status = ST_NOT_GGA;
      else if (!sum_present || ln_hex_val != ln_xor) r.status = ST_BAD_SUM;
      else if (int'(ln_field) + 1 < MIN_FIELDS) r.status = ST_FEW_FIELDS;
      else r.status = ST_OK;
      r.calc_checksum = ln_xor;
      r.recv_checksum = ln_hex_val;
      r.field_count = ln_field + 6'd1;
      r.fix_quality = ln_fix;
      r.sats_used = ln_sats;
      expected_line_results.push_back(r);
      lines_predicted++;
      clear_line_state();
    end
  endtask

  // results side: random stall and field-by-field compare
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got_line = m_tdata;
      if (expected_line_results.size() == 0) begin
        report_mismatch("result with no line pending, status", got_line.status, 0);
      end else begin
        want_line = expected_line_results.pop_front();
        if (got_line.status != want_line.status)
          report_mismatch("status", got_line.status, want_line.status);
        if (got_line.calc_checksum != want_line.calc_checksum)
          report_mismatch("calc_checksum", got_line.calc_checksum, want_line.calc_checksum);
        if (got_line.recv_checksum != want_line.recv_checksum)
          report_mismatch("recv_checksum", got_line.recv_checksum, want_line.recv_checksum);
        if (got_line.field_count != want_line.field_count)
          report_mismatch("field_count", got_line.field_count, want_line.field_count);
        if (got_line.fix_quality != want_line.fix_quality)
          report_mismatch("fix_quality", got_line.fix_quality, want_line.fix_quality);
        if (got_line.sats_used != want_line.sats_used)
          report_mismatch("sats_used", got_line.sats_used, want_line.sats_used);
        status_seen[want_line.status]++;
      end
      lines_checked++;
    end
  end

  task send_char(input logic [7:0] ch);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gga_line_step(ch);
    chars_sent++;
  endtask

  task send_line_buf();
    foreach (line_buf[i]) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return CH_ZERO + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // xor of the buffered sentence, leading dollar excluded
  function automatic logic [7:0] body_xor();
    logic [7:0] x;
    x = '0;
    foreach (line_buf[i]) begin
      if (!(i == 0 && line_buf[i] == CH_DOLLAR)) x ^= line_buf[i];
    end
    return x;
  endfunction

  function automatic void push_sum_val(input logic [7:0] v, input bit lower);
    line_buf.push_back(CH_STAR);
    line_buf.push_back(hex_char(v[7:4], lower));
    line_buf.push_back(hex_char(v[3:0], lower));
  endfunction

  task send_raw(input string s);
    line_buf.delete();
    push_str(s);
    send_line_buf();
  endtask

  task send_with_sum(input string body, input bit lower);
    line_buf.delete();
    push_str(body);
    push_sum_val(body_xor(), lower);
    push_str("\r\n");
    send_line_buf();
  endtask

  function automatic void push_text();
    int n;
    logic [7:0] c;
    n = $urandom_range(0, 5);
    repeat (n) begin
      c = 8'($urandom_range(32, 126));
      if (c == CH_COMMA || c == CH_STAR) c = CH_DOT;
      line_buf.push_back(c);
    end
  endfunction

  function automatic void push_number();
    int r;
    int n;
    r = $urandom_range(99);
    if (r >= 12) begin
      if (r < 22) line_buf.push_back($urandom_range(1) ? 8'h2d : 8'h20);
      n = $urandom_range(1, 4);
      repeat (n) line_buf.push_back(8'($urandom_range(48, 57)));
      if ($urandom_range(9) == 0) push_str(".5");
    end
  endfunction

  task build_gga_line();
    int r;
    int n_fields;
    logic [7:0] sum;
    bit lower;
    line_buf.delete();
    push_str("$GPGGA");
    if ($urandom_range(99) < 8) line_buf[$urandom_range(5)] = 8'($urandom_range(0, 255));
    r = $urandom_range(99);
    if (r < 60) n_fields = MIN_FIELDS;
    else if (r < 80) n_fields = $urandom_range(MIN_FIELDS + 1, 20);
    else if (r < 92) n_fields = $urandom_range(1, MIN_FIELDS - 1);
    else n_fields = $urandom_range(FIELD_LIMIT_DEF - 2, FIELD_LIMIT_DEF + 8);
    for (int k = 1; k < n_fields; k++) begin
      line_buf.push_back(CH_COMMA);
      if (k == FIX_FIELD || k == SATS_FIELD) push_number();
      else push_text();
    end
    sum = body_xor();
    lower = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 66) begin
      push_sum_val(sum, lower);
    end else if (r < 74) begin
      push_sum_val(sum ^ 8'($urandom_range(1, 255)), lower);
    end else if (r < 80) begin
      line_buf.push_back(CH_STAR);
      line_buf.push_back(hex_char(sum[3:0], lower));
      line_buf.push_back(CH_CR);
    end else if (r < 85) begin
      line_buf.push_back(CH_STAR);
      line_buf.push_back(hex_char(sum[3:0], lower));
    end else if (r < 89) begin
      // no checksum at all
    end else if (r < 94) begin
      push_sum_val(sum, lower);
      push_str("*7F,,");
    end else begin
      line_buf.push_back(CH_STAR);
      line_buf.push_back($urandom_range(1) ? 8'h47 : 8'h20);
    end
    if ($urandom_range(1)) line_buf.push_back(CH_CR);
    line_buf.push_back(CH_NEWLINE);
  endtask

  task build_random_line();
    int r;
    int k;
    int n;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 72) begin
      build_gga_line();
    end else if (r < 82) begin
      build_gga_line();
      k = $urandom_range(1, line_buf.size() - 1);
      while (line_buf.size() > k) void'(line_buf.pop_back());
      line_buf.push_back(CH_NEWLINE);
    end else if (r < 97) begin
      line_buf.delete();
      n = $urandom_range(1, 40);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      line_buf.push_back(CH_NEWLINE);
    end else begin
      line_buf.delete();
      repeat (LINE_MAX_DEF) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_NEWLINE) c = "~";
        line_buf.push_back(c);
      end
    end
  endtask

  task test_header_cases();
    send_with_sum("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", 1'b0);
    send_with_sum("$GPGSA,A,3,04,05,,09,12,,,24,,,,,2.5,1.3,2.1", 1'b0);
    send_raw("$GP\n");
    send_raw("\n");
    send_raw("GPGGA,1,2,,,,,,,,,,,,,*00\n");
    line_buf.delete();
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hff);
    line_buf.push_back(CH_NEWLINE);
    send_line_buf();
  endtask

  task test_checksum_cases();
    send_with_sum("$GPGGA,092750.000,5321.6802,N,00630.3372,W,1,8,1.03,61.7,M,55.2,M,,", 1'b1);
    line_buf.delete();
    push_str("$GPGGA,1,2,3,4,5,6,7,8,9,10,11,12,13,14");
    push_sum_val(body_xor() ^ 8'h01, 1'b0);
    push_str("\r\n");
    send_line_buf();
    // one digit that matches a small checksum, followed by another character
    send_raw("$GPGGA,X,,,,,,,,,,,,,*E\r\n");
    send_raw("$GPGGA,X,,,,,,,,,,,,,*e\n");
    send_raw("$GPGGA,X,,,,,,,,,,,,,*\n");
    send_raw("$GPGGA,X,,,,,,,,,,,,,**0E\n");
    send_raw("$GPGGA,X,,,,,,,,,,,,,*G5\n");
    send_raw("$GPGGA,X,,,,,,,,,,,,,\n");
    line_buf.delete();
    push_str("$GPGGA,,,,,,2,11,,,,,,,,");
    push_sum_val(body_xor(), 1'b1);
    push_str("*12*,,\n");
    send_line_buf();
  endtask

  task test_field_cases();
    send_with_sum("$GPGGA,1,2,3,4,5,-3, 12,x,,,,,,,", 1'b0);
    send_with_sum("$GPGGA,,,,,,999,0300,,,,,,,,", 1'b0);
    send_with_sum("$GPGGA,,,,,,4.5,12a3,,,,,,,,", 1'b1);
    send_with_sum("$GPGGA,,,,,,1,5,,,", 1'b0);
    line_buf.delete();
    push_str("$GPGGA");
    repeat (FIELD_LIMIT_DEF + 8) line_buf.push_back(CH_COMMA);
    push_sum_val(body_xor(), 1'b0);
    line_buf.push_back(CH_NEWLINE);
    send_line_buf();
    line_buf.delete();
    push_str("$GPGGA,,,");
    push_sum_val(body_xor(), 1'b0);
    push_str(",,,,,,,,,,,,,,\n");
    send_line_buf();
  endtask

  task test_line_limit();
    line_buf.delete();
    push_str("$GPGGA,,,,,,7,255,,,,,,,,");
    push_sum_val(body_xor(), 1'b0);
    while (line_buf.size() < LINE_MAX_DEF) line_buf.push_back("x");
    send_line_buf();
    line_buf.delete();
    repeat (LINE_MAX_DEF) line_buf.push_back("A");
    send_line_buf();
    send_with_sum("$GPGGA,,,,,,2,9,,,,,,,,", 1'b0);
  endtask

  task test_random_traffic();
    int start_chars;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end
      endcase
      start_chars = chars_sent;
      while (chars_sent - start_chars < 75) begin
        build_random_line();
        send_line_buf();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_line_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_cases();
    test_checksum_cases();
    test_field_cases();
    test_line_limit();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (expected_line_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_line_results.size() != 0)
      report_mismatch("lines left without result", expected_line_results.size(), 0);
    $display("%0d characters sent in %0d lines, %0d results checked, %0d mismatches",
             chars_sent, lines_predicted, lines_checked, err_count);
    $display("status mix: accepted %0d, not gga %0d, bad checksum %0d, few fields %0d",
             status_seen[ST_OK], status_seen[ST_NOT_GGA], status_seen[ST_BAD_SUM],
             status_seen[ST_FEW_FIELDS]);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/nglc_pkg.sv
rtl/nglc_line_state.sv
rtl/nmea_gga_line_checker.sv
rtl/nglc_checker.sv
tb/sv/nmea_gga_line_checker_tb.sv
